### hdl/bfu_pkg.sv
// Shared types and constants for the batch frame uploader.
// Used by bfu_ctrl, bfu_dp and batch_frame_uploader; no dependencies.
package bfu_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int TIMEOUT_W    = 16;
    localparam int RLIM_W       = 5;
    localparam int ADDR_W       = 16;
    localparam int BYTE_W       = 8;
    localparam int ENTRY_W      = ADDR_W + BYTE_W;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RST  = 16'd150;
    localparam logic [RLIM_W-1:0]    REINIT_LIMIT_RST = 5'd10;

    localparam logic [BYTE_W-1:0] BYTE_SYNC0 = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_ESC   = 8'h7D;
    localparam logic [BYTE_W-1:0] BYTE_FRAME = 8'h7E;
    localparam logic [BYTE_W-1:0] BYTE_FULL  = 8'h7F;
    localparam logic [BYTE_W-1:0] BYTE_ACK   = 8'h6F;

    localparam logic REG_ACK_TIMEOUT  = 1'b0;
    localparam logic REG_REINIT_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        OP_POST  = 2'd0,
        OP_FLUSH = 2'd1,
        OP_TICK  = 2'd2,
        OP_RX    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STS_ACCEPTED = 3'd0,
        STS_FULL     = 3'd1,
        STS_EMPTY    = 3'd2,
        STS_ACK_OK   = 3'd3,
        STS_ACK_FAIL = 3'd4,
        STS_BUSY     = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        OSRC_STATUS    = 3'd0,
        OSRC_CONST     = 3'd1,
        OSRC_COUNT     = 3'd2,
        OSRC_ENTRY_HI  = 3'd3,
        OSRC_ENTRY_MID = 3'd4,
        OSRC_ENTRY_LO  = 3'd5
    } out_src_t;

    typedef struct packed {
        logic              load_out;
        out_src_t          src;
        logic [BYTE_W-1:0] const_byte;
        status_t           sts;
        logic              is_last;
        logic              store_entry;
        logic              clr_count;
        logic              start_wait;
        logic              inc_tick;
        logic              finish;
        logic              ack_ok;
        logic              rd_first;
        logic              rd_next;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic awaiting;
        logic count_zero;
        logic count_full;
        logic tick_expired;
        logic rx_is_ack;
        logic idx_last;
    } dp_status_t;

endpackage

### hdl/batch_frame_uploader.sv
// Top level of the batch frame uploader: APB register file, sequencer and
// datapath. Depends on bfu_pkg, bfu_ctrl and bfu_dp.
//
// Usage: each input transfer carries an operation (post, flush, tick,
// received byte) with its fields. Each output transfer carries either a
// byte to transmit (is_byte = 1) or a status code; last marks the final
// transfer caused by one input.
// Results are registered: one shows in the cycle after its input transfer.
// Throughput: a full-batch post emits ESC, FULL and a FULL status; a flush
// of N entries emits SYNC0, ESC, FRAME, the count and three bytes per entry,
// one frame byte per cycle through the output register while it is not
// stalled. Input is stalled until a frame is completely queued.
// Output stall: the output register holds its payload; the sequencer
// pauses and input stays stalled until the register drains.
// Reset: batch count, wait state and output valid clear; ack_timeout
// returns to 150 and reinit_limit to 10. Stored entries are not cleared
// and are only read below the count.
// Configuration: ack_timeout at 0x0, reinit_limit at 0x4; write only
// while idle.
module batch_frame_uploader
    import bfu_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            operation,
    input  logic [ADDR_W-1:0]     node_address,
    input  logic [BYTE_W-1:0]     node_data,
    input  logic [BYTE_W-1:0]     rx_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  is_byte,
    output logic [BYTE_W-1:0]     tx_byte,
    output logic [2:0]            status,
    output logic                  last,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [TIMEOUT_W-1:0] ack_timeout_reg;
    logic [RLIM_W-1:0]    reinit_limit_reg;
    logic                 reg_wr;
    logic                 reg_sel;
    cmd_t                 cmd;
    dp_status_t           dp_sts;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign reg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_timeout_reg  <= ACK_TIMEOUT_RST;
            reinit_limit_reg <= REINIT_LIMIT_RST;
        end
        else if (reg_wr)
        begin
            if (reg_sel == REG_ACK_TIMEOUT)
                ack_timeout_reg <= pwdata[TIMEOUT_W-1:0];
            else
                reinit_limit_reg <= pwdata[RLIM_W-1:0];
        end
    end

    always_comb
    begin
        if (reg_sel == REG_REINIT_LIMIT)
            prdata = APB_DATA_W'(reinit_limit_reg);
        else
            prdata = APB_DATA_W'(ack_timeout_reg);
    end

    bfu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .dp_sts    (dp_sts),
        .cmd       (cmd)
    );

    bfu_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .dp_sts       (dp_sts),
        .node_address (node_address),
        .node_data    (node_data),
        .rx_byte      (rx_byte),
        .ack_timeout  (ack_timeout_reg),
        .reinit_limit (reinit_limit_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .is_byte      (is_byte),
        .tx_byte      (tx_byte),
        .status       (status),
        .last         (last)
    );

endmodule

### hdl/bfu_ctrl.sv
// Sequencer for the batch frame uploader: decodes the operation and steps
// through frame emission. Depends on bfu_pkg; drives bfu_dp via cmd_t.
module bfu_ctrl
    import bfu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] operation,
    input  dp_status_t dp_sts,
    output cmd_t       cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_FULL1 = 9'b000000010,
        S_FULL2 = 9'b000000100,
        S_HDR1  = 9'b000001000,
        S_HDR2  = 9'b000010000,
        S_CNT   = 9'b000100000,
        S_ADRH  = 9'b001000000,
        S_ADRL  = 9'b010000000,
        S_DATA  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    op_t    op;

    assign op       = op_t'(operation);
    assign in_stall = !((state_reg == S_IDLE) && dp_sts.out_free);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_POST:
                        begin
                            cmd.load_out = 1'b1;
                            if (dp_sts.awaiting)
                            begin
                                cmd.sts     = STS_BUSY;
                                cmd.is_last = 1'b1;
                            end
                            else if (!dp_sts.count_full)
                            begin
                                cmd.store_entry = 1'b1;
                                cmd.sts         = STS_ACCEPTED;
                                cmd.is_last     = 1'b1;
                            end
                            else
                            begin
                                cmd.src        = OSRC_CONST;
                                cmd.const_byte = BYTE_ESC;
                                cmd.clr_count  = 1'b1;
                                state_next     = S_FULL1;
                            end
                        end
                        OP_FLUSH:
                        begin
                            cmd.load_out = 1'b1;
                            if (dp_sts.awaiting)
                            begin
                                cmd.sts     = STS_BUSY;
                                cmd.is_last = 1'b1;
                            end
                            else if (dp_sts.count_zero)
                            begin
                                cmd.sts     = STS_EMPTY;
                                cmd.is_last = 1'b1;
                            end
                            else
                            begin
                                cmd.src        = OSRC_CONST;
                                cmd.const_byte = BYTE_SYNC0;
                                cmd.start_wait = 1'b1;
                                state_next     = S_HDR1;
                            end
                        end
                        OP_TICK:
                        begin
                            if (dp_sts.awaiting)
                            begin
                                if (dp_sts.tick_expired)
                                begin
                                    cmd.finish   = 1'b1;
                                    cmd.load_out = 1'b1;
                                    cmd.sts      = STS_ACK_FAIL;
                                    cmd.is_last  = 1'b1;
                                end
                                else
                                begin
                                    cmd.inc_tick = 1'b1;
                                end
                            end
                        end
                        OP_RX:
                        begin
                            if (dp_sts.awaiting)
                            begin
                                cmd.finish   = 1'b1;
                                cmd.ack_ok   = dp_sts.rx_is_ack;
                                cmd.load_out = 1'b1;
                                cmd.sts      = dp_sts.rx_is_ack ? STS_ACK_OK : STS_ACK_FAIL;
                                cmd.is_last  = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd = '0;
                        end
                    endcase
                end
            end
            S_FULL1:
            begin
                if (dp_sts.out_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.src        = OSRC_CONST;
                    cmd.const_byte = BYTE_FULL;
                    state_next     = S_FULL2;
                end
            end
            S_FULL2:
            begin
                if (dp_sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.sts      = STS_FULL;
                    cmd.is_last  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_HDR1:
            begin
                if (dp_sts.out_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.src        = OSRC_CONST;
                    cmd.const_byte = BYTE_ESC;
                    state_next     = S_HDR2;
                end
            end
            S_HDR2:
            begin
                if (dp_sts.out_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.src        = OSRC_CONST;
                    cmd.const_byte = BYTE_FRAME;
                    state_next     = S_CNT;
                end
            end
            S_CNT:
            begin
                if (dp_sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.src      = OSRC_COUNT;
                    cmd.rd_first = 1'b1;
                    state_next   = S_ADRH;
                end
            end
            S_ADRH:
            begin
                if (dp_sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.src      = OSRC_ENTRY_HI;
                    state_next   = S_ADRL;
                end
            end
            S_ADRL:
            begin
                if (dp_sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.src      = OSRC_ENTRY_MID;
                    state_next   = S_DATA;
                end
            end
            S_DATA:
            begin
                if (dp_sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.src      = OSRC_ENTRY_LO;
                    if (dp_sts.idx_last)
                    begin
                        cmd.is_last = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                        state_next  = S_ADRH;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### hdl/bfu_dp.sv
// Datapath for the batch frame uploader: entry store, count, ack wait
// state and the output register. Depends on bfu_pkg; driven by bfu_ctrl.
module bfu_dp
    import bfu_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output dp_status_t           dp_sts,
    input  logic [ADDR_W-1:0]    node_address,
    input  logic [BYTE_W-1:0]    node_data,
    input  logic [BYTE_W-1:0]    rx_byte,
    input  logic [TIMEOUT_W-1:0] ack_timeout,
    input  logic [RLIM_W-1:0]    reinit_limit,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 is_byte,
    output logic [BYTE_W-1:0]    tx_byte,
    output logic [2:0]           status,
    output logic                 last
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMPW = (CW > RLIM_W) ? CW : RLIM_W;

    logic [ENTRY_W-1:0]   mem [DEPTH];
    logic [ENTRY_W-1:0]   rd_data_reg;
    logic [AW-1:0]        idx_reg;
    logic [AW-1:0]        rd_addr;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic                 awaiting_reg;
    logic                 awaiting_next;
    logic [TIMEOUT_W-1:0] wait_reg;
    logic [TIMEOUT_W-1:0] wait_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 is_byte_reg;
    logic [BYTE_W-1:0]    tx_byte_reg;
    logic [2:0]           status_reg;
    logic                 last_reg;
    logic [BYTE_W-1:0]    byte_sel;

    assign dp_sts.out_free     = !out_valid_reg || !out_stall;
    assign dp_sts.awaiting     = awaiting_reg;
    assign dp_sts.count_zero   = (count_reg == '0);
    assign dp_sts.count_full   = (count_reg == CW'(DEPTH));
    assign dp_sts.tick_expired = (wait_reg >= ack_timeout);
    assign dp_sts.rx_is_ack    = (rx_byte == BYTE_ACK);
    assign dp_sts.idx_last     = ((CW'(idx_reg) + CW'(1)) == count_reg);

    assign rd_addr = cmd.rd_first ? '0 : AW'(idx_reg + AW'(1));

    always_comb
    begin
        count_next    = count_reg;
        awaiting_next = awaiting_reg;
        wait_next     = wait_reg;
        if (cmd.store_entry)
            count_next = count_reg + CW'(1);
        if (cmd.clr_count)
            count_next = '0;
        if (cmd.start_wait)
        begin
            awaiting_next = 1'b1;
            wait_next     = '0;
        end
        if (cmd.inc_tick)
            wait_next = wait_reg + TIMEOUT_W'(1);
        if (cmd.finish)
        begin
            awaiting_next = 1'b0;
            wait_next     = '0;
            if (cmd.ack_ok || (CMPW'(count_reg) > CMPW'(reinit_limit)))
                count_next = '0;
        end
    end

    always_comb
    begin
        case (cmd.src)
            OSRC_STATUS:    byte_sel = '0;
            OSRC_CONST:     byte_sel = cmd.const_byte;
            OSRC_COUNT:     byte_sel = BYTE_W'(count_reg);
            OSRC_ENTRY_HI:  byte_sel = rd_data_reg[ENTRY_W-1 -: BYTE_W];
            OSRC_ENTRY_MID: byte_sel = rd_data_reg[2*BYTE_W-1 -: BYTE_W];
            OSRC_ENTRY_LO:  byte_sel = rd_data_reg[BYTE_W-1:0];
            default:        byte_sel = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (cmd.load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            awaiting_reg  <= 1'b0;
            wait_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            awaiting_reg  <= awaiting_next;
            wait_reg      <= wait_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_entry)
            mem[count_reg[AW-1:0]] <= {node_address, node_data};
        if (cmd.rd_first || cmd.rd_next)
        begin
            idx_reg     <= rd_addr;
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            is_byte_reg <= (cmd.src != OSRC_STATUS);
            tx_byte_reg <= byte_sel;
            status_reg  <= (cmd.src == OSRC_STATUS) ? cmd.sts : STS_ACCEPTED;
            last_reg    <= cmd.is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign is_byte   = is_byte_reg;
    assign tx_byte   = tx_byte_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule
